FILE: sv/sli_pkg.sv
// shared types and constants for the sorted list block
// no dependencies; imported by every module of the block

package sli_pkg;

    // width of a stored value and default list depth
    localparam int VALUE_WIDTH  = 32;
    localparam int DEF_CAPACITY = 32;
    localparam int COUNT_WIDTH  = 6;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_APPEND  = 2'd1,
        OP_DELETE  = 2'd2,
        OP_READOUT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_DATA,
        S_TAIL,
        S_DONE
    } t_state;

    // input beat
    typedef struct packed {
        t_op                            op;
        logic signed [VALUE_WIDTH-1:0]  value;
    } t_in;

    // output beat
    typedef struct packed {
        t_status                        status;
        logic signed [VALUE_WIDTH-1:0]  element;
        logic                           element_valid;
        logic                           last;
        logic [COUNT_WIDTH-1:0]         entry_count;
    } t_out;

    // flags from the shared compare unit
    typedef struct packed {
        logic eq;
        logic gt;
    } t_cmp;

endpackage

FILE: sv/sli_mem.sv
// entry storage: one write port, one read port with registered read data
// depends on sli_pkg for the value width

module sli_mem import sli_pkg::*; #(
    parameter  int DEPTH = DEF_CAPACITY,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic signed [VALUE_WIDTH-1:0] i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic signed [VALUE_WIDTH-1:0] o_rdata
);

    logic signed [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/sli_cmp.sv
// shared compare unit: signed equal and greater-than of an entry against the operand
// depends on sli_pkg for the value width and flag struct

module sli_cmp import sli_pkg::*; (
    input  logic signed [VALUE_WIDTH-1:0] i_entry,
    input  logic signed [VALUE_WIDTH-1:0] i_operand,
    output t_cmp                          o_flags
);

    // one wide subtract-style compare, shared by insert and delete scans
    always_comb begin
        o_flags.eq = (i_entry == i_operand);
        o_flags.gt = (i_entry > i_operand);
    end

endmodule

FILE: sv/sorted_list_insert_delete_top.sv
// sorted list top: sequencer scanning the entry memory through one compare unit
// insert/delete scan each entry through S_ADDR and S_DATA, insert then writes S_TAIL; append goes straight to S_TAIL
// readout reads each entry through S_ADDR and S_DATA, limited by the single registered read port
// the input stalls for the whole operation; the output register frees it from the sink
// reset clears the count and control; memory contents are left as they are
// depends on sli_pkg, sli_mem and sli_cmp

module sorted_list_insert_delete_top import sli_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state                        r_state, n_state;
    t_op                           r_op, n_op;
    logic signed [VALUE_WIDTH-1:0] r_val, n_val;
    logic signed [VALUE_WIDTH-1:0] r_carry, n_carry;
    logic [CW-1:0]                 r_idx, n_idx;
    logic [CW-1:0]                 r_count, n_count;
    logic                          r_found, n_found;
    t_status                       r_status, n_status;
    logic                          r_out_valid, n_out_valid;
    t_out                          r_out, n_out;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic signed [VALUE_WIDTH-1:0] mem_wdata;
    logic                          mem_re;
    logic signed [VALUE_WIDTH-1:0] mem_rdata;
    t_cmp                          cmp;
    logic                          out_free;
    logic                          in_accept;
    logic                          idx_last;
    logic [CW-1:0]                 idx_inc;
    logic [CW-1:0]                 idx_dec;

    sli_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    sli_cmp u_cmp (
        .i_entry   (mem_rdata),
        .i_operand (r_val),
        .o_flags   (cmp)
    );

    // handshake helpers
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign idx_inc    = r_idx + CW'(1);
    assign idx_dec    = r_idx - CW'(1);
    assign idx_last   = (idx_inc == r_count);

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_carry  <= n_carry;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_out    <= n_out;
    end

    // sequencer: next state, memory control and output beat
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_carry     = r_carry;
        n_idx       = r_idx;
        n_count     = r_count;
        n_found     = r_found;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_waddr   = r_idx[AW-1:0];
        mem_wdata   = r_val;
        mem_re      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_op    = i_in_data.op;
                    n_val   = i_in_data.value;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_status = ST_OK;
                    case (i_in_data.op)
                        OP_READOUT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_ADDR;
                            end
                        end
                        OP_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_ADDR;
                            end
                        end
                        OP_APPEND: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_TAIL;
                            end
                        end
                        default: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else if (r_count == '0) begin
                                n_state = S_TAIL;
                            end else begin
                                n_state = S_ADDR;
                            end
                        end
                    endcase
                end
            end

            S_ADDR: begin
                mem_re  = 1'b1;
                n_state = S_DATA;
            end

            S_DATA: begin
                case (r_op)
                    OP_READOUT: begin
                        // one beat per entry once the output register frees
                        if (out_free) begin
                            n_out_valid         = 1'b1;
                            n_out.status        = ST_OK;
                            n_out.element       = mem_rdata;
                            n_out.element_valid = 1'b1;
                            n_out.last          = idx_last;
                            n_out.entry_count   = COUNT_WIDTH'(r_count);
                            n_idx               = idx_inc;
                            n_state             = idx_last ? S_IDLE : S_ADDR;
                        end
                    end
                    OP_DELETE: begin
                        // after the match, every later entry moves down by one
                        if (r_found) begin
                            mem_we    = 1'b1;
                            mem_waddr = idx_dec[AW-1:0];
                            mem_wdata = mem_rdata;
                        end else if (cmp.eq) begin
                            n_found = 1'b1;
                        end
                        n_idx = idx_inc;
                        if (idx_last) begin
                            n_state = S_DONE;
                            if (r_found || cmp.eq) begin
                                n_count  = r_count - CW'(1);
                                n_status = ST_OK;
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end else begin
                            n_state = S_ADDR;
                        end
                    end
                    default: begin
                        // insert: drop the value at the first greater entry, ripple the rest up
                        if (r_found) begin
                            mem_we    = 1'b1;
                            mem_wdata = r_carry;
                            n_carry   = mem_rdata;
                        end else if (cmp.gt) begin
                            mem_we    = 1'b1;
                            mem_wdata = r_val;
                            n_carry   = mem_rdata;
                            n_found   = 1'b1;
                        end
                        n_idx   = idx_inc;
                        n_state = idx_last ? S_TAIL : S_ADDR;
                    end
                endcase
            end

            S_TAIL: begin
                // write the new high end: the value itself or the last displaced entry
                mem_we    = 1'b1;
                mem_waddr = r_count[AW-1:0];
                mem_wdata = r_found ? r_carry : r_val;
                n_count   = r_count + CW'(1);
                n_status  = ST_OK;
                n_state   = S_DONE;
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = r_status;
                    n_out.element       = '0;
                    n_out.element_valid = 1'b0;
                    n_out.last          = 1'b1;
                    n_out.entry_count   = COUNT_WIDTH'(r_count);
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // count stays within the list depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    // an accepted beat always moves the sequencer out of idle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state != S_IDLE)
        else $error("sequencer idle right after accept");

    // memory is never written while idle or emitting a result
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE || r_state == S_ADDR) |-> !mem_we)
        else $error("memory write outside a scan step");

    // count changes only at the end of an insert, append or delete
    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_ADDR || r_state == S_DONE)
            |=> $stable(r_count))
        else $error("entry count changed outside an update step");

    // a beat carrying an entry is always an ok readout beat
    a_entry_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.element_valid) |-> r_out.status == ST_OK)
        else $error("entry beat with error status");

endmodule
